[hdl/rbt_pkg.sv]
// ----------------------------------------------------------------------------
// rbt_pkg
// Shared field widths, request codes and phase codes of the reliable
// broadcast tracker.
// ----------------------------------------------------------------------------
package rbt_pkg;

    localparam int REQ_W    = 3;
    localparam int IDX_W    = 8;
    localparam int SENDER_W = 6;
    localparam int NODE_W   = 7;
    localparam int PHASE_W  = 2;

    typedef logic [REQ_W-1:0]   req_t;
    typedef logic [PHASE_W-1:0] phase_t;

    localparam req_t REQ_INIT  = 3'd0;
    localparam req_t REQ_ECHO  = 3'd1;
    localparam req_t REQ_READY = 3'd2;
    localparam req_t REQ_START = 3'd3;
    localparam req_t REQ_QUERY = 3'd4;

    localparam phase_t PH_INIT      = 2'd0;
    localparam phase_t PH_ECHOED    = 2'd1;
    localparam phase_t PH_READY     = 2'd2;
    localparam phase_t PH_DELIVERED = 2'd3;

    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 7'd4;

endpackage

[hdl/rbt_mem.sv]
// ----------------------------------------------------------------------------
// rbt_mem
// Slot state memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rbt_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 144,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/reliable_broadcast_tracker.sv]
// ----------------------------------------------------------------------------
// reliable_broadcast_tracker
// Per-slot phase tracker for reliable broadcast with echo and ready quorums.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in channel (req_type, instance_index, sender_id)
//   under valid/ready; one result per request leaves on the out channel
//   (send_init, send_echo, send_ready, deliver, phase_after) under
//   valid/ready. The node count is written on the cfg channel, which is
//   always ready; write it only while no request is in flight.
//   Each request is handled by a read of the slot's entry from the state
//   memory, then an update that writes changes back and loads the result register.
//   The result is valid on the cycle after the update. A new request is not
//   taken until the previous one has been updated, as the slot memory has a
//   single read-modify-write path. After reset the block clears the state
//   memory, one slot per cycle, until every slot is cleared; in_ready stays
//   low meanwhile. The node count resets to 4.
//   When the receiver stalls, the result stays in the output register and
//   a new request is taken only in the cycle the held result leaves.
// ----------------------------------------------------------------------------
module reliable_broadcast_tracker #(
    parameter int INSTANCE_SLOTS = 256,
    parameter int MAX_NODES      = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rbt_pkg::NODE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rbt_pkg::REQ_W-1:0]     req_type,
    input  logic [rbt_pkg::IDX_W-1:0]     instance_index,
    input  logic [rbt_pkg::SENDER_W-1:0]  sender_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          send_init,
    output logic                          send_echo,
    output logic                          send_ready,
    output logic                          deliver,
    output logic [rbt_pkg::PHASE_W-1:0]   phase_after
);

    import rbt_pkg::*;

    localparam int SLOT_W = (INSTANCE_SLOTS > 1) ? $clog2(INSTANCE_SLOTS) : 1;
    localparam int SEL_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    typedef struct packed {
        phase_t               phase;
        logic [MAX_NODES-1:0] echo_map;
        logic [MAX_NODES-1:0] ready_map;
        logic [CNT_W-1:0]     echo_cnt;
        logic [CNT_W-1:0]     ready_cnt;
    } slot_t;

    localparam int WORD_W = $bits(slot_t);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // Saturate n to 1..MAX_NODES and return f = floor((n-1)/3).
    // (n-1)*43 >> 7 equals (n-1)/3 for n-1 below 64.
    function automatic logic [NODE_W-1:0] faults_of(input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] n;
        logic [12:0]       prod;
        n = v;
        if (n == '0)
        begin
            n = NODE_W'(1);
        end
        else if (n > NODE_W'(MAX_NODES))
        begin
            n = NODE_W'(MAX_NODES);
        end
        prod = 13'(n - NODE_W'(1)) * 13'd43;
        return NODE_W'(prod >> 7);
    endfunction

    function automatic logic [CNT_W-1:0] quorum_of(input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] n;
        n = v;
        if (n == '0)
        begin
            n = NODE_W'(1);
        end
        else if (n > NODE_W'(MAX_NODES))
        begin
            n = NODE_W'(MAX_NODES);
        end
        return CNT_W'(n - faults_of(v));
    endfunction

    function automatic logic [CNT_W-1:0] amplify_of(input logic [NODE_W-1:0] v);
        return CNT_W'(faults_of(v) + NODE_W'(1));
    endfunction

    // Index modulo slot count by shifted compare and subtract.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        r = idx;
        for (int k = IDX_W - 1; k >= 0; k--)
        begin
            if (32'(r) >= (32'(INSTANCE_SLOTS) << k))
            begin
                r = r - IDX_W'(32'(INSTANCE_SLOTS) << k);
            end
        end
        return SLOT_W'(r);
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]    quorum_reg, amplify_reg;
    req_t                req_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SENDER_W-1:0] sender_reg;
    logic                out_valid_reg;
    logic                send_init_reg, send_echo_reg, send_ready_reg, deliver_reg;
    phase_t              phase_reg;

    logic              accept;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    slot_t             cur, upd;
    logic              upd_we;
    logic              sender_ok;
    logic [SEL_W-1:0]  sel;
    phase_t            ph;
    logic              s_init, s_echo, s_ready, dlv;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quorum_reg  <= quorum_of(NODE_COUNT_RESET);
            amplify_reg <= amplify_of(NODE_COUNT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            quorum_reg  <= quorum_of(cfg_data);
            amplify_reg <= amplify_of(cfg_data);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                if (clr_cnt_reg == SLOT_W'(INSTANCE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Hold the request fields for the update cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_type;
            slot_reg   <= slot_of(instance_index);
            sender_reg <= sender_id;
        end
    end

    // Update of the entry read for the held request.
    assign cur       = slot_t'(mem_rdata);
    assign sender_ok = 7'(sender_reg) < 7'(MAX_NODES);
    assign sel       = sender_reg[SEL_W-1:0];

    always_comb
    begin
        upd     = cur;
        ph      = cur.phase;
        upd_we  = 1'b0;
        s_init  = 1'b0;
        s_echo  = 1'b0;
        s_ready = 1'b0;
        dlv     = 1'b0;
        case (req_reg)
            REQ_START:
            begin
                s_init = 1'b1;
            end
            REQ_INIT:
            begin
                if (ph == PH_INIT)
                begin
                    s_echo = 1'b1;
                    ph     = PH_ECHOED;
                    upd_we = 1'b1;
                end
            end
            REQ_ECHO:
            begin
                if (ph != PH_DELIVERED)
                begin
                    upd_we = 1'b1;
                    if (sender_ok && !cur.echo_map[sel])
                    begin
                        upd.echo_map[sel] = 1'b1;
                        upd.echo_cnt      = cur.echo_cnt + CNT_W'(1);
                    end
                    if ((ph == PH_INIT || ph == PH_ECHOED) &&
                        upd.echo_cnt >= quorum_reg)
                    begin
                        s_ready = 1'b1;
                        ph      = PH_READY;
                    end
                end
            end
            REQ_READY:
            begin
                if (ph != PH_DELIVERED)
                begin
                    upd_we = 1'b1;
                    if (sender_ok && !cur.ready_map[sel])
                    begin
                        upd.ready_map[sel] = 1'b1;
                        upd.ready_cnt      = cur.ready_cnt + CNT_W'(1);
                    end
                    if ((ph == PH_INIT || ph == PH_ECHOED) &&
                        upd.ready_cnt >= amplify_reg)
                    begin
                        s_ready = 1'b1;
                        ph      = PH_READY;
                    end
                    if (upd.ready_cnt >= quorum_reg)
                    begin
                        dlv = 1'b1;
                        ph  = PH_DELIVERED;
                    end
                end
            end
            default:
            begin
                // query and unused kinds only report the phase
            end
        endcase
        upd.phase = ph;
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = (state_reg == ST_EXEC) && upd_we;
            mem_waddr = slot_reg;
            mem_wdata = WORD_W'(upd);
        end
    end

    rbt_mem #(
        .DEPTH (INSTANCE_SLOTS),
        .WIDTH (WORD_W),
        .AW    (SLOT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (slot_of(instance_index)),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_EXEC)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            send_init_reg  <= s_init;
            send_echo_reg  <= s_echo;
            send_ready_reg <= s_ready;
            deliver_reg    <= dlv;
            phase_reg      <= ph;
        end
    end

    assign out_valid   = out_valid_reg;
    assign send_init   = send_init_reg;
    assign send_echo   = send_echo_reg;
    assign send_ready  = send_ready_reg;
    assign deliver     = deliver_reg;
    assign phase_after = phase_reg;

endmodule

[hdl/rbt_checker.sv]
// ----------------------------------------------------------------------------
// rbt_checker
// Port-level checks of the reliable broadcast tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rbt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        send_init,
    input logic                        send_echo,
    input logic                        send_ready,
    input logic                        deliver,
    input logic [rbt_pkg::PHASE_W-1:0] phase_after
);

    import rbt_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase_after) &&
            $stable(deliver) && $stable(send_ready) && $stable(send_echo) &&
            $stable(send_init))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && deliver |-> phase_after == PH_DELIVERED)
        else $error("deliver without delivered phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_echo |-> phase_after == PH_ECHOED && !send_ready && !deliver)
        else $error("echo send with wrong phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_ready && !deliver |-> phase_after == PH_READY)
        else $error("ready send with wrong phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_init |-> !send_echo && !send_ready && !deliver)
        else $error("start request changed state");

endmodule

bind reliable_broadcast_tracker rbt_checker u_rbt_checker (.*);
